// ----- sv/bmh_pkg.sv -----
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared types, sizes and helpers for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmh_pkg;

  localparam int CAPACITY      = 256;
  localparam int PAYLOAD_WIDTH = 16;
  localparam int KEY_W         = 32;
  localparam int KIND_W        = 2;
  localparam int STATUS_W      = 2;

  // slot index 1..CAPACITY, also the entry count 0..CAPACITY
  localparam int IDX_W  = $clog2(CAPACITY + 1);
  // storage address: slot minus one
  localparam int ADDR_W = $clog2(CAPACITY);

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH    = 2'd0,
    KIND_POP     = 2'd1,
    KIND_REPLACE = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_POP_RD,
    ST_POP_LD,
    ST_DN_RD,
    ST_DN_SEL,
    ST_DN_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic [PAYLOAD_WIDTH-1:0] pay;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr0;
    logic [ADDR_W-1:0] raddr1;
  } mem_req_t;

  typedef struct packed {
    status_t                  status;
    logic                     min_valid;
    logic signed [KEY_W-1:0]  min_key;
    logic [PAYLOAD_WIDTH-1:0] min_payload;
    logic [IDX_W-1:0]         count;
  } result_t;

  // slot number (1-based, one bit of headroom) to storage address
  function automatic logic [ADDR_W-1:0] slot_addr(input logic [IDX_W:0] slot);
    logic [IDX_W:0] s;
    begin
      s = slot - 1'b1;
      return s[ADDR_W-1:0];
    end
  endfunction

endpackage

// ----- sv/bmh_cmp.sv -----
// ----------------------------------------------------------------------------
// bmh_cmp
// Shared signed key comparator used by every sift step.
// ----------------------------------------------------------------------------
module bmh_cmp
  import bmh_pkg::*;
(
  input  logic signed [KEY_W-1:0] a,
  input  logic signed [KEY_W-1:0] b,
  output logic                    lt,
  output logic                    le
);

  assign lt = (a < b);
  assign le = (a <= b);

endmodule

// ----- sv/bmh_store.sv -----
// ----------------------------------------------------------------------------
// bmh_store
// Heap entry storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bmh_store
  import bmh_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd0,
  output entry_t   rd1
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd0 <= mem[req.raddr0];
    rd1 <= mem[req.raddr1];
  end

endmodule

// ----- sv/bmh_ctrl.sv -----
// ----------------------------------------------------------------------------
// bmh_ctrl
// Sift sequencer: walks the heap one level at a time, sharing one comparator.
// ----------------------------------------------------------------------------
module bmh_ctrl
  import bmh_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [KIND_W-1:0]        kind,
  input  logic signed [KEY_W-1:0]  key,
  input  logic [PAYLOAD_WIDTH-1:0] payload,
  output logic                     busy,
  output mem_req_t                 mreq,
  input  entry_t                   rd0,
  input  entry_t                   rd1,
  output logic                     res_valid,
  input  logic                     res_take,
  output result_t                  res
);

  localparam logic [IDX_W-1:0] CAP_CNT = IDX_W'(CAPACITY);
  localparam logic [IDX_W-1:0] ONE     = IDX_W'(1);

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt;     // live entries
  logic [IDX_W-1:0] n;       // walk limit (count at start of pop/replace)
  logic [IDX_W-1:0] idx;     // hole position
  logic [IDX_W-1:0] cidx;    // chosen child
  logic             hasr;    // right child exists
  entry_t           nent;    // entry being placed
  entry_t           cent;    // chosen child entry
  entry_t           root;    // copy of slot 1
  status_t          stat;

  logic signed [KEY_W-1:0] cmp_a, cmp_b;
  logic                    cmp_lt, cmp_le;
  logic [IDX_W:0]          child;
  logic [IDX_W-1:0]        parent;

  assign child  = {idx, 1'b0};
  assign parent = idx >> 1;

  bmh_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt),
    .le (cmp_le)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (kind_t'(kind))
            KIND_PUSH:    state_next = (cnt >= CAP_CNT) ? ST_DONE : ST_UP_RD;
            KIND_POP:     state_next = (cnt == '0) ? ST_DONE : ST_POP_RD;
            KIND_REPLACE: state_next = (cnt == '0) ? ST_DONE : ST_DN_RD;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_UP_RD:  state_next = (idx == ONE) ? ST_DONE : ST_UP_CMP;
      ST_UP_CMP: state_next = cmp_le ? ST_DONE : ST_UP_RD;
      ST_POP_RD: state_next = ST_POP_LD;
      ST_POP_LD: state_next = ST_DN_RD;
      ST_DN_RD:  state_next = (child > {1'b0, n}) ? ST_DONE : ST_DN_SEL;
      ST_DN_SEL: state_next = ST_DN_CMP;
      ST_DN_CMP: state_next = cmp_le ? ST_DONE : ST_DN_RD;
      ST_DONE:   state_next = res_take ? ST_IDLE : ST_DONE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // storage requests and comparator operands
  always_comb begin
    mreq        = '0;
    mreq.wdata  = nent;
    mreq.waddr  = slot_addr({1'b0, idx});
    cmp_a       = nent.key;
    cmp_b       = cent.key;
    case (state)
      ST_UP_RD: begin
        if (idx == ONE) begin
          mreq.we = 1'b1;
        end else begin
          mreq.raddr0 = slot_addr({1'b0, parent});
        end
      end
      ST_UP_CMP: begin
        // parent key <= new key: new entry settles here
        cmp_a      = rd0.key;
        cmp_b      = nent.key;
        mreq.we    = 1'b1;
        mreq.wdata = cmp_le ? nent : rd0;
      end
      ST_POP_RD: begin
        mreq.raddr0 = slot_addr({1'b0, n});
      end
      ST_DN_RD: begin
        if (child > {1'b0, n}) begin
          mreq.we = 1'b1;
        end else begin
          mreq.raddr0 = slot_addr(child);
          mreq.raddr1 = slot_addr({idx, 1'b1});
        end
      end
      ST_DN_SEL: begin
        // right wins only when strictly smaller
        cmp_a = rd1.key;
        cmp_b = rd0.key;
      end
      ST_DN_CMP: begin
        mreq.we    = 1'b1;
        mreq.wdata = cmp_le ? nent : cent;
      end
      default: begin
        mreq.we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && start) begin
        case (kind_t'(kind))
          KIND_PUSH: if (cnt < CAP_CNT) cnt <= cnt + 1'b1;
          KIND_POP:  if (cnt != '0) cnt <= cnt - 1'b1;
          default:   cnt <= cnt;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (mreq.we && mreq.waddr == '0) begin
      root <= mreq.wdata;
    end
    case (state)
      ST_IDLE: begin
        if (start) begin
          stat     <= STAT_DONE;
          nent.key <= key;
          nent.pay <= payload;
          n        <= cnt;
          case (kind_t'(kind))
            KIND_PUSH: begin
              idx <= cnt + 1'b1;
              if (cnt >= CAP_CNT) stat <= STAT_FULL;
            end
            KIND_POP: begin
              if (cnt == '0) stat <= STAT_EMPTY;
            end
            KIND_REPLACE: begin
              idx <= ONE;
              if (cnt == '0) stat <= STAT_EMPTY;
            end
            default: stat <= STAT_DONE;
          endcase
        end
      end
      ST_UP_CMP: begin
        if (!cmp_le) idx <= parent;
      end
      ST_POP_LD: begin
        nent <= rd0;
        idx  <= ONE;
      end
      ST_DN_RD: begin
        cidx <= child[IDX_W-1:0];
        hasr <= ({idx, 1'b1} <= {1'b0, n});
      end
      ST_DN_SEL: begin
        if (hasr && cmp_lt) begin
          cent <= rd1;
          cidx <= cidx | ONE;
        end else begin
          cent <= rd0;
        end
      end
      ST_DN_CMP: begin
        if (!cmp_le) idx <= cidx;
      end
      default: begin
        stat <= stat;
      end
    endcase
  end

  assign busy      = (state != ST_IDLE);
  assign res_valid = (state == ST_DONE);

  always_comb begin
    res.status      = stat;
    res.min_valid   = (cnt != '0);
    res.min_key     = res.min_valid ? root.key : '0;
    res.min_payload = res.min_valid ? root.pay : '0;
    res.count       = cnt;
  end

  // count stays within capacity
  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP_CNT)
    else $error("entry count above capacity");

  // an accepted word always leaves idle
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> (state != ST_IDLE))
    else $error("accepted word did not start the sequencer");

  // the hole only moves downward on sift-down
  a_dn_child: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DN_CMP) |-> (cidx > idx && cidx <= n))
    else $error("sift-down child outside the live range");

  // writes land inside the slots live when the word started (pop may still
  // touch the old last slot) or the slot being added by a push
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    mreq.we |-> (idx != '0 && (idx <= cnt || idx <= n)))
    else $error("heap write outside live slots");

endmodule

// ----- sv/binary_min_heap_top.sv -----
// ----------------------------------------------------------------------------
// binary_min_heap_top
// Binary min-heap priority queue of signed keys with payloads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) takes one word: kind (0 push, 1 pop
//   min, 2 replace min), key and payload. Output channel (out_valid/
//   out_stall) returns one word per input: status, the root entry after
//   the operation (min_valid, min_key, min_payload; zeros when empty) and
//   the entry count.
//   in_stall stays high from acceptance until the result is loaded into
//   the output register. Each heap level takes a parent read and a
//   compare/write on a push, and a two-child read, a child select and a
//   compare/write on a pop or replace, all through one comparator and a
//   two-read one-write store; a pop first reads the last entry and loads
//   it as the entry to place. At most log2(CAPACITY) = 8 levels are moved.
//   Full, empty and unused kinds go straight to the done state. A new
//   word is accepted while a result still waits in the output register;
//   if out_stall holds it, the next result waits in the sequencer's done
//   state. Synchronous reset empties the heap (count 0); storage contents
//   are not cleared.
// ----------------------------------------------------------------------------
module binary_min_heap_top
  import bmh_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [KIND_W-1:0]        kind,
  input  logic signed [KEY_W-1:0]  key,
  input  logic [PAYLOAD_WIDTH-1:0] payload,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      status,
  output logic                     min_valid,
  output logic signed [KEY_W-1:0]  min_key,
  output logic [PAYLOAD_WIDTH-1:0] min_payload,
  output logic [IDX_W-1:0]         count
);

  mem_req_t mreq;
  entry_t   rd0, rd1;
  logic     busy;
  logic     res_valid, res_take;
  result_t  res;
  result_t  out_word;

  bmh_store u_store (
    .clk (clk),
    .req (mreq),
    .rd0 (rd0),
    .rd1 (rd1)
  );

  bmh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && !in_stall),
    .kind      (kind),
    .key       (key),
    .payload   (payload),
    .busy      (busy),
    .mreq      (mreq),
    .rd0       (rd0),
    .rd1       (rd1),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign in_stall = busy;

  // output register loads when empty or being drained this cycle
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_word <= res;
    end
  end

  assign status      = out_word.status;
  assign min_valid   = out_word.min_valid;
  assign min_key     = out_word.min_key;
  assign min_payload = out_word.min_payload;
  assign count       = out_word.count;

endmodule
